FILE: hw/rtl/boc_pkg.sv
// ----------------------------------------------------------------------------
// Box counting occupancy package
// Shared widths, constants and the operation record passed from the front
// end to the back end through the operation queue.
// ----------------------------------------------------------------------------
package boc_pkg;

  localparam int MAX_AXES     = 16;
  localparam int BOX_CAPACITY = 1 << 20;
  localparam int INDEX_W      = $clog2(BOX_CAPACITY);
  localparam int AXIS_W       = 4;
  localparam int COUNT_W      = 5;
  localparam int COORD_W      = 32;
  localparam int SCALE_W      = 32;
  localparam int RADIX_W      = 21;
  localparam int DIST_W       = 21;
  localparam int PART_W       = 24;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    CMD_SETUP = 2'd0,
    CMD_COORD = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_COORD = 2'd0,
    OP_DROP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [RADIX_W-1:0]   cell_num;
    logic [RADIX_W-1:0]   radix;
    logic                 last;
  } op_t;

  typedef enum logic [0:0] {
    REG_AXIS_COUNT = 1'b0,
    REG_BOX_SCALE  = 1'b1
  } reg_idx_t;

endpackage

FILE: hw/rtl/boc_queue.sv
// ----------------------------------------------------------------------------
// Operation queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module boc_queue #(
  parameter int DEPTH = boc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  boc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output boc_pkg::op_t pop_op
);
  import boc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign nonempty = (fill != '0);
  assign pop_op   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/boc_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, keeps the axis tables and particle position, and turns
// each coordinate into a saturated cell number for the back end.
// ----------------------------------------------------------------------------
module boc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [boc_pkg::AXIS_W-1:0]    axis,
  input  logic signed [boc_pkg::COORD_W-1:0] value,
  input  logic [boc_pkg::RADIX_W-1:0]   radix,
  input  logic [boc_pkg::COUNT_W-1:0]   axis_count,
  input  logic [boc_pkg::SCALE_W-1:0]   box_scale,
  input  logic                          hold,
  output logic                          push,
  output boc_pkg::op_t                  push_op,
  input  logic                          queue_full
);
  import boc_pkg::*;

  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int POS_W  = $clog2(MAX_AXES);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t       state;
  logic [COORD_W-1:0] origin [MAX_AXES];
  logic [RADIX_W-1:0] radix_tab [MAX_AXES];
  logic [POS_W-1:0]   pos;
  logic [COORD_W-1:0] offset;
  logic [PROD_W-1:0]  prod;
  logic [RADIX_W-1:0] radix_r;
  logic               last_r;
  op_kind_t           kind_r;

  logic                     accept;
  logic [COUNT_W-1:0]       count;
  logic                     is_last;
  logic signed [COORD_W:0]  diff;
  logic [PROD_W-1:0]        rounded;
  logic [PROD_W-29:0]       cell_wide;
  logic [RADIX_W-1:0]       cell_num;
  logic                     setup_ok;

  assign in_ready = (state == F_IDLE) && !hold;
  assign accept   = in_valid && in_ready;
  assign setup_ok = ({1'b0, axis} < (AXIS_W + 1)'(MAX_AXES));

  always_comb begin
    count = axis_count;
    if (axis_count == '0) begin
      count = COUNT_W'(1);
    end else if (axis_count > COUNT_W'(MAX_AXES)) begin
      count = COUNT_W'(MAX_AXES);
    end
  end

  assign is_last = ({1'b0, pos} + 1'b1) >= count;
  assign diff    = {value[COORD_W-1], value} -
                   $signed({origin[pos][COORD_W-1], origin[pos]});

  // Q20.12 times Q16.16 leaves 28 fraction bits; add one half and drop them.
  assign rounded   = prod + (PROD_W'(1) << 27);
  assign cell_wide = rounded[PROD_W-1:28];
  assign cell_num  = (cell_wide >= (PROD_W - 28)'(radix_r)) ?
                     radix_r - 1'b1 : cell_wide[RADIX_W-1:0];

  assign push = (state == F_PUSH) && !queue_full;
  always_comb begin
    push_op          = '0;
    push_op.kind     = kind_r;
    push_op.cell_num = cell_num;
    push_op.radix    = radix_r;
    push_op.last     = last_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        origin[i]    <= '0;
        radix_tab[i] <= RADIX_W'(1);
      end
    end else if (accept && cmd == CMD_SETUP && setup_ok) begin
      origin[axis[POS_W-1:0]]    <= value;
      radix_tab[axis[POS_W-1:0]] <= (radix == '0) ? RADIX_W'(1) : radix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      offset  <= (diff > 0) ? diff[COORD_W-1:0] : '0;
      radix_r <= radix_tab[pos];
      last_r  <= is_last;
    end
    if (state == F_MUL) begin
      prod <= offset * box_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      pos    <= '0;
      kind_r <= OP_DROP;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_COORD: begin
                kind_r <= OP_COORD;
                pos    <= is_last ? '0 : pos + 1'b1;
                state  <= F_MUL;
              end
              CMD_SETUP: begin
                if (setup_ok) begin
                  kind_r <= OP_DROP;
                  pos    <= '0;
                  state  <= F_PUSH;
                end
              end
              CMD_CLEAR: begin
                kind_r <= OP_CLEAR;
                pos    <= '0;
                state  <= F_PUSH;
              end
              default: ;
            endcase
          end
        end
        F_MUL: state <= F_PUSH;
        F_PUSH: begin
          if (!queue_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/boc_back.sv
// ----------------------------------------------------------------------------
// Back end
// Folds cells into the mixed radix index, marks the occupancy bitmap and
// keeps the running counters. Clears the bitmap by a sweep.
// ----------------------------------------------------------------------------
module boc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  input  boc_pkg::op_t                 op,
  output logic                         pop,
  output logic                         sweeping,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [boc_pkg::INDEX_W-1:0]  box_index,
  output logic                         is_new_box,
  output logic [boc_pkg::DIST_W-1:0]   distinct_boxes,
  output logic [boc_pkg::PART_W-1:0]   particle_number,
  output logic                         out_of_range
);
  import boc_pkg::*;

  localparam int PROD_W = INDEX_W + RADIX_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef enum logic [6:0] {
    B_SWEEP = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_MAC   = 7'b0000100,
    B_ADD   = 7'b0001000,
    B_READ  = 7'b0010000,
    B_MARK  = 7'b0100000,
    B_OUT   = 7'b1000000
  } back_state_t;

  back_state_t        state;
  op_t                cur;
  logic [INDEX_W-1:0] acc;
  logic               ovf;
  logic [PROD_W-1:0]  prod;
  logic [INDEX_W-1:0] sweep_addr;
  logic [DIST_W-1:0]  distinct;
  logic [PART_W-1:0]  particles;
  logic               occupancy [BOX_CAPACITY];
  logic               rd_bit;

  logic [SUM_W-1:0]   idx;
  logic               mem_we;
  logic [INDEX_W-1:0] mem_addr;
  logic               fresh;

  assign pop      = (state == B_IDLE) && op_valid;
  assign sweeping = (state == B_SWEEP);
  assign out_valid = (state == B_OUT);
  assign idx      = SUM_W'(prod) + SUM_W'(cur.cell_num);
  assign fresh    = !ovf && !rd_bit;
  assign mem_we   = sweeping || ((state == B_MARK) && fresh);
  assign mem_addr = sweeping ? sweep_addr : acc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occupancy[mem_addr] <= !sweeping;
    end
    rd_bit <= occupancy[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= op;
    end
    if (state == B_MAC) begin
      prod <= acc * cur.radix;
    end
    if (state == B_MARK) begin
      box_index    <= ovf ? '0 : acc;
      is_new_box   <= fresh;
      out_of_range <= ovf;
      distinct_boxes  <= (fresh && distinct != '1) ? distinct + 1'b1 : distinct;
      particle_number <= (particles != '1) ? particles + 1'b1 : particles;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_addr <= '0;
      acc        <= '0;
      ovf        <= 1'b0;
      distinct   <= '0;
      particles  <= '0;
    end else begin
      case (state)
        B_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == INDEX_W'(BOX_CAPACITY - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (op_valid) begin
            case (op.kind)
              OP_COORD: state <= B_MAC;
              OP_DROP: begin
                acc <= '0;
                ovf <= 1'b0;
              end
              OP_CLEAR: begin
                acc        <= '0;
                ovf        <= 1'b0;
                distinct   <= '0;
                particles  <= '0;
                sweep_addr <= '0;
                state      <= B_SWEEP;
              end
              default: ;
            endcase
          end
        end
        B_MAC: state <= B_ADD;
        B_ADD: begin
          if (!ovf) begin
            if (idx >= SUM_W'(BOX_CAPACITY)) begin
              ovf <= 1'b1;
              acc <= '0;
            end else begin
              acc <= idx[INDEX_W-1:0];
            end
          end
          state <= cur.last ? B_READ : B_IDLE;
        end
        B_READ: state <= B_MARK;
        B_MARK: begin
          if (fresh && distinct != '1) begin
            distinct <= distinct + 1'b1;
          end
          if (particles != '1) begin
            particles <= particles + 1'b1;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            acc   <= '0;
            ovf   <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/box_counting_occupancy.sv
// With the queue empty, a result follows the last coordinate of its particle through the front
// end (multiply, then round and saturate) and then the back end (pop, multiply, add, bitmap
// read, mark). The front end takes a new request only after the previous one is pushed to the
// queue; the back end handles one operation at a time, and the last coordinate of a particle
// also takes the bitmap read, mark and result handshake. Reset and clear requests start a sweep
// of BOX_CAPACITY (1048576) bitmap entries, one entry a cycle, during which no request is accepted.
// ----------------------------------------------------------------------------
// Box counting occupancy
// Counts distinct grid boxes occupied by a stream of particles at one box
// size, with an APB register port for the axis count and the box scale.
// ----------------------------------------------------------------------------
module box_counting_occupancy #(
  parameter int QUEUE_DEPTH = boc_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           cmd,
  input  logic [boc_pkg::AXIS_W-1:0]           axis,
  input  logic signed [boc_pkg::COORD_W-1:0]   value,
  input  logic [boc_pkg::RADIX_W-1:0]          radix,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [boc_pkg::INDEX_W-1:0]          box_index,
  output logic                                 is_new_box,
  output logic [boc_pkg::DIST_W-1:0]           distinct_boxes,
  output logic [boc_pkg::PART_W-1:0]           particle_number,
  output logic                                 out_of_range
);
  import boc_pkg::*;

  logic [COUNT_W-1:0] axis_count;
  logic [SCALE_W-1:0] box_scale;
  logic               push;
  op_t                push_op;
  logic               queue_full;
  logic               pop;
  logic               nonempty;
  op_t                pop_op;
  logic               sweeping;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= COUNT_W'(2);
      box_scale  <= SCALE_W'(65536);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_AXIS_COUNT: axis_count <= pwdata[COUNT_W-1:0];
        REG_BOX_SCALE:  box_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AXIS_COUNT: prdata = 32'(axis_count);
      REG_BOX_SCALE:  prdata = box_scale;
      default:        prdata = '0;
    endcase
  end

  boc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .axis       (axis),
    .value      (value),
    .radix      (radix),
    .axis_count (axis_count),
    .box_scale  (box_scale),
    .hold       (sweeping),
    .push       (push),
    .push_op    (push_op),
    .queue_full (queue_full)
  );

  boc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (queue_full),
    .pop      (pop),
    .nonempty (nonempty),
    .pop_op   (pop_op)
  );

  boc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .op_valid        (nonempty),
    .op              (pop_op),
    .pop             (pop),
    .sweeping        (sweeping),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .box_index       (box_index),
    .is_new_box      (is_new_box),
    .distinct_boxes  (distinct_boxes),
    .particle_number (particle_number),
    .out_of_range    (out_of_range)
  );

endmodule

FILE: sim/box_counting_occupancy_checker.sv
// ----------------------------------------------------------------------------
// Box counting occupancy checker
// Watches the register port, the request channel and the result channel, predicts the box of
// every completed particle and compares each result field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module box_counting_occupancy_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic [boc_pkg::AXIS_W-1:0]          axis,
  input  logic signed [boc_pkg::COORD_W-1:0]  value,
  input  logic [boc_pkg::RADIX_W-1:0]         radix,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [boc_pkg::INDEX_W-1:0]         box_index,
  input  logic                                is_new_box,
  input  logic [boc_pkg::DIST_W-1:0]          distinct_boxes,
  input  logic [boc_pkg::PART_W-1:0]          particle_number,
  input  logic                                out_of_range,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import boc_pkg::*;

  typedef struct {
    logic [INDEX_W-1:0] box;
    logic               fresh;
    logic [DIST_W-1:0]  distinct;
    logic [PART_W-1:0]  particles;
    logic               overflow;
  } box_result_t;

  box_result_t           box_results[$];
  logic [COUNT_W-1:0]    axes_per_particle;
  logic [SCALE_W-1:0]    inv_box_edge;
  logic [COORD_W-1:0]    origin_of[MAX_AXES];
  logic [RADIX_W-1:0]    boxes_along[MAX_AXES];
  int unsigned           next_axis;
  longint unsigned       partial_index;
  logic                  partial_overflow;
  bit                    occupied[int unsigned];
  int unsigned           distinct_total;
  int unsigned           particle_total;

  assign pending = box_results.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void restart_particle();
    next_axis = 0;
    partial_index = 0;
    partial_overflow = 0;
  endfunction

  function automatic longint unsigned cell_number(input logic signed [COORD_W-1:0] coord,
                                                  input int unsigned ax);
    longint offset;
    logic [127:0] scaled;
    longint unsigned cell_val;
    offset = longint'(coord) - longint'($signed(origin_of[ax]));
    if (offset <= 0) return 0;
    scaled = (128'(offset) * 128'(inv_box_edge) + (128'd1 << 27)) >> 28;
    if (scaled >= 128'(boxes_along[ax])) cell_val = boxes_along[ax] - 1;
    else cell_val = scaled[63:0];
    return cell_val;
  endfunction

  task automatic predict_request();
    int unsigned count;
    int unsigned ax;
    longint unsigned idx;
    box_result_t r;
    case (cmd_t'(cmd))
      CMD_SETUP: begin
        origin_of[axis] = value;
        boxes_along[axis] = (radix == 0) ? 1 : radix;
        restart_particle();
      end
      CMD_CLEAR: begin
        occupied.delete();
        distinct_total = 0;
        particle_total = 0;
        restart_particle();
      end
      CMD_COORD: begin
        count = axes_per_particle;
        if (count == 0) count = 1;
        if (count > MAX_AXES) count = MAX_AXES;
        ax = (next_axis >= MAX_AXES) ? MAX_AXES - 1 : next_axis;
        if (!partial_overflow) begin
          idx = partial_index * boxes_along[ax] + cell_number(value, ax);
          if (idx >= BOX_CAPACITY) begin
            partial_overflow = 1;
            partial_index = 0;
          end else begin
            partial_index = idx;
          end
        end
        if (next_axis + 1 < count) begin
          next_axis++;
        end else begin
          r.fresh = 0;
          if (!partial_overflow && !occupied.exists(partial_index)) begin
            occupied[partial_index] = 1;
            r.fresh = 1;
            if (distinct_total < 2097151) distinct_total++;
          end
          if (particle_total < 16777215) particle_total++;
          r.box = partial_overflow ? '0 : partial_index[INDEX_W-1:0];
          r.distinct = distinct_total;
          r.particles = particle_total;
          r.overflow = partial_overflow;
          box_results = {box_results, r};
          restart_particle();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    box_result_t want;
    if (rst) begin
      axes_per_particle <= 2;
      inv_box_edge <= 65536;
      for (int i = 0; i < MAX_AXES; i++) begin
        origin_of[i] = '0;
        boxes_along[i] = 1;
      end
      occupied.delete();
      distinct_total = 0;
      particle_total = 0;
      restart_particle();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * REG_AXIS_COUNT)) axes_per_particle <= pwdata[COUNT_W-1:0];
        else if (paddr == 3'(4 * REG_BOX_SCALE)) inv_box_edge <= pwdata;
      end
      if (in_valid && in_ready) predict_request();
      if (out_valid && out_ready) begin
        if (box_results.size() == 0) begin
          report("unexpected result", box_index, -1);
        end else begin
          want = box_results.pop_front();
          if (box_index !== want.box) report("box_index", box_index, want.box);
          if (is_new_box !== want.fresh) report("is_new_box", is_new_box, want.fresh);
          if (distinct_boxes !== want.distinct)
            report("distinct_boxes", distinct_boxes, want.distinct);
          if (particle_number !== want.particles)
            report("particle_number", particle_number, want.particles);
          if (out_of_range !== want.overflow)
            report("out_of_range", out_of_range, want.overflow);
        end
      end
    end
  end

  initial errors = 0;

endmodule

FILE: sim/box_counting_occupancy_tb.sv
// ----------------------------------------------------------------------------
// Box counting occupancy testbench
// Drives directed and random setup, coordinate and clear requests through
// several axis count and box scale settings, with random idling on both
// sides; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module box_counting_occupancy_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import boc_pkg::*;

  logic                       clk = 0;
  logic                       rst = 1;
  logic                       psel = 0, penable = 0, pwrite = 0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid = 0, in_ready;
  logic [1:0]                 cmd = CMD_NONE;
  logic [AXIS_W-1:0]          axis = '0;
  logic signed [COORD_W-1:0]  value = '0;
  logic [RADIX_W-1:0]         radix = '0;
  logic                       out_valid, out_ready = 0;
  logic [INDEX_W-1:0]         box_index;
  logic                       is_new_box;
  logic [DIST_W-1:0]          distinct_boxes;
  logic [PART_W-1:0]          particle_number;
  logic                       out_of_range;
  int                         errors, pending;

  bit                         send_gaps, take_gaps;
  int                         long_hold = 0;
  logic [COORD_W-1:0]         origins[MAX_AXES];
  int unsigned                radices[MAX_AXES];
  int unsigned                cur_count, cur_scale;

  box_counting_occupancy DUT (.*);

  box_counting_occupancy_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #200ms;
    $display("box_counting_occupancy_tb: errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = take_gaps ? $urandom_range(0, 10) : 0;
      if (long_hold > 0) begin
        gap = long_hold;
        long_hold = 0;
      end
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(input cmd_t c, input int unsigned ax, input logic [31:0] v,
                      input int unsigned r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    axis <= AXIS_W'(ax);
    value <= v;
    radix <= RADIX_W'(r);
    in_valid <= 1;
    if (c == CMD_SETUP && r != 0) begin
      origins[ax] = v;
      radices[ax] = r;
    end
    if (c == CMD_SETUP && r == 0) begin
      origins[ax] = v;
      radices[ax] = 1;
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    wait (pending == 0);
    do @(posedge clk); while (!in_ready);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    settle();
    psel <= 1;
    pwrite <= 1;
    paddr <= 3'(4 * idx);
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_AXIS_COUNT) cur_count = data[COUNT_W-1:0];
    else cur_scale = data;
  endtask

  // A coordinate aimed at a cell near the axis's box range, or anywhere.
  function automatic logic [31:0] aim(input int unsigned ax);
    longint span;
    if ($urandom_range(0, 3) == 0) return $urandom;
    span = (longint'(radices[ax]) + 2) * (64'd1 << 28) / (cur_scale == 0 ? 1 : cur_scale);
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    return origins[ax] + 32'($urandom_range(0, 32'(span)));
  endfunction

  function automatic int unsigned radix_limit();
    int unsigned c;
    c = (cur_count == 0) ? 1 : (cur_count > MAX_AXES ? MAX_AXES : cur_count);
    if (c == 1) return 1048576;
    if (c == 2) return 1024;
    if (c == 3) return 101;
    if (c <= 5) return 16;
    if (c <= 10) return 4;
    return 2;
  endfunction

  task automatic setup_all();
    int unsigned r;
    for (int a = 0; a < MAX_AXES; a++) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2097151)
                                      : $urandom_range(1, radix_limit());
      send(CMD_SETUP, a, $urandom, r);
    end
  endtask

  task automatic particle();
    int unsigned c;
    c = (cur_count == 0) ? 1 : (cur_count > MAX_AXES ? MAX_AXES : cur_count);
    for (int a = 0; a < c; a++) send(CMD_COORD, $urandom_range(0, 15), aim(a), $urandom);
  endtask

  initial begin
    int unsigned counts[7] = '{2, 1, 3, 16, 0, 17, 31};
    int unsigned scales[7] = '{65536, 1, 32'hFFFF_FFFF, 4096, 65536, 1 << 20, 200000};
    int sent;
    send_gaps = 1;
    take_gaps = 1;
    cur_count = 2;
    cur_scale = 65536;
    for (int a = 0; a < MAX_AXES; a++) begin
      origins[a] = 0;
      radices[a] = 1;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: zero radix, widest radix, field extremes, drops and ignored codes.
    send(CMD_SETUP, 0, 0, 0);
    send(CMD_SETUP, 1, 32'h8000_0000, 1048576);
    send(CMD_COORD, 0, 32'h7FFF_FFFF, 0);
    send(CMD_COORD, 0, 32'h7FFF_FFFF, 0);
    send(CMD_COORD, 5, 32'h8000_0000, 32'h1F_FFFF);
    send(CMD_SETUP, 15, 32'hFFFF_FFFF, 32'h1F_FFFF);
    send(CMD_COORD, 0, 0, 0);
    send(CMD_SETUP, 0, 32'h0000_1000, 1024);
    send(CMD_COORD, 0, 32'h0000_1000, 0);
    send(CMD_NONE, 15, 32'hFFFF_FFFF, 32'h1F_FFFF);
    send(CMD_COORD, 0, 32'h0000_0800, 0);
    send(CMD_SETUP, 1, 32'h0000_0000, 1048576);
    send(CMD_COORD, 0, 32'h0040_0000, 0);
    send(CMD_COORD, 0, 32'h0040_0000, 0);
    send(CMD_COORD, 0, 32'h0000_1800, 0);
    send(CMD_COORD, 0, 32'h0000_17FF, 0);
    send(CMD_CLEAR, 0, 0, 0);
    send(CMD_COORD, 0, 32'h0000_1800, 0);
    send(CMD_COORD, 0, 32'h0000_17FF, 0);
    write_reg(REG_AXIS_COUNT, 3);
    send(CMD_SETUP, 2, 32'hFFFF_0000, 7);
    send(CMD_COORD, 0, 32'h0000_2000, 0);
    send(CMD_COORD, 0, 32'h0000_3000, 0);
    // Shrinking the axis count mid-particle makes the next coordinate the last one.
    write_reg(REG_AXIS_COUNT, 1);
    send(CMD_COORD, 0, 32'h0001_0000, 0);

    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_AXIS_COUNT, counts[ph]);
      write_reg(REG_BOX_SCALE, (ph == 6) ? $urandom_range(1, 32'hFFFF_FFFF) : scales[ph]);
      setup_all();
      sent += 16;
      if (ph == 3) begin
        long_hold = 400;
        send_gaps = 0;
      end
      while (sent < 70 * (ph + 1)) begin
        case ($urandom_range(0, 19))
          0: begin
            send(CMD_SETUP, $urandom_range(0, 15), $urandom, $urandom_range(0, 2097151));
            sent++;
          end
          1: begin
            send(CMD_NONE, $urandom_range(0, 15), $urandom, $urandom);
            sent++;
          end
          2: begin
            send(CMD_COORD, 0, $urandom, 0);
            sent++;
          end
          default: begin
            particle();
            sent += (cur_count == 0) ? 1 : (cur_count > 16 ? 16 : cur_count);
          end
        endcase
        if ($urandom_range(0, 30) == 0) begin
          send_gaps = !send_gaps;
          take_gaps = $urandom_range(0, 1);
        end
      end
      if (ph == 2) begin
        // Sender waits for every outstanding result before going on.
        in_valid <= 0;
        wait (pending == 0);
        @(negedge clk);
        send(CMD_CLEAR, 0, 0, 0);
        particle();
        particle();
      end
      send_gaps = 1;
      take_gaps = 1;
    end

    in_valid <= 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("box_counting_occupancy_tb: clean");
    end else begin
      $display("box_counting_occupancy_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/boc_pkg.sv
hw/rtl/boc_queue.sv
hw/rtl/boc_front.sv
hw/rtl/boc_back.sv
hw/rtl/box_counting_occupancy.sv
sim/box_counting_occupancy_checker.sv
sim/box_counting_occupancy_tb.sv
